/* hdl/circle_through_three_points_defines.svh */
// Assertion macros for the circle-through-three-points block.
`ifndef CIRCLE_THROUGH_THREE_POINTS_DEFINES_SVH
`define CIRCLE_THROUGH_THREE_POINTS_DEFINES_SVH
`ifndef SYNTHESIS
`define C3P_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define C3P_ASSERT_COMB(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`else
`define C3P_ASSERT(label, prop, msg)
`define C3P_ASSERT_COMB(label, expr, msg)
`endif
`endif

/* hdl/c3p_pkg.sv */
// Types and widths shared by the circle-through-three-points pipeline.
package c3p_pkg;
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS + 2;
    localparam int DEN_W      = 2 * COORD_BITS + 3;
    localparam int NUM_W      = 3 * COORD_BITS + 3;
    localparam int DEN_MAG_W  = DEN_W - 1;
    localparam int NUM_MAG_W  = NUM_W - 1;
    localparam int QUO_W      = NUM_MAG_W + FRAC_BITS;
    localparam int QEXT_W     = (QUO_W > 33) ? QUO_W : 33;
    localparam int ERR_W      = 34;
    localparam int ROOT_W     = 32;
    localparam int SQRT_REM_W = ROOT_W + 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
        logic [COORD_BITS-1:0] third_x;
        logic [COORD_BITS-1:0] third_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [31:0]        radius_out;
        logic               collinear;
    } t_out_item;

    typedef struct packed {
        logic                  collinear;
        logic                  neg_x;
        logic                  neg_y;
        logic [DEN_MAG_W-1:0]  den;
        logic [DEN_MAG_W-1:0]  rem_x;
        logic [DEN_MAG_W-1:0]  rem_y;
        logic [QUO_W-1:0]      quo_x;
        logic [QUO_W-1:0]      quo_y;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
    } t_div_stage;

    typedef struct packed {
        logic                  collinear;
        logic                  sat;
        logic signed [31:0]    cx;
        logic signed [31:0]    cy;
        logic [2*ROOT_W-1:0]   n;
        logic [SQRT_REM_W-1:0] rem;
        logic [ROOT_W-1:0]     root;
    } t_sqrt_stage;
endpackage

/* hdl/c3p_front.sv */
// Front pipeline: edge vectors, squared norms, cross products and dividend setup.
module c3p_front import c3p_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_in_item   i_item,
    output logic       o_valid,
    output t_div_stage o_stage
);
    logic r_a_valid, r_b_valid, r_c_valid;

    // Stage A
    logic signed [DIFF_W-1:0] n_dx2, n_dy2, n_dx3, n_dy3;
    logic signed [SQ_W-1:0]   n_s2, n_s3;
    logic [SQ_W-1:0]          w_q1, w_q2, w_q3;
    logic signed [DIFF_W-1:0] r_dx2, r_dy2, r_dx3, r_dy3;
    logic signed [SQ_W-1:0]   r_s2, r_s3;
    logic [COORD_BITS-1:0]    r_a_x1, r_a_y1;

    always_comb begin
        n_dx2 = $signed({1'b0, i_item.second_x}) - $signed({1'b0, i_item.first_x});
        n_dy2 = $signed({1'b0, i_item.second_y}) - $signed({1'b0, i_item.first_y});
        n_dx3 = $signed({1'b0, i_item.third_x}) - $signed({1'b0, i_item.first_x});
        n_dy3 = $signed({1'b0, i_item.third_y}) - $signed({1'b0, i_item.first_y});
        w_q1  = SQ_W'(i_item.first_x) * SQ_W'(i_item.first_x)
              + SQ_W'(i_item.first_y) * SQ_W'(i_item.first_y);
        w_q2  = SQ_W'(i_item.second_x) * SQ_W'(i_item.second_x)
              + SQ_W'(i_item.second_y) * SQ_W'(i_item.second_y);
        w_q3  = SQ_W'(i_item.third_x) * SQ_W'(i_item.third_x)
              + SQ_W'(i_item.third_y) * SQ_W'(i_item.third_y);
        n_s2  = $signed(w_q2 - w_q1);
        n_s3  = $signed(w_q3 - w_q1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx2  <= n_dx2;
            r_dy2  <= n_dy2;
            r_dx3  <= n_dx3;
            r_dy3  <= n_dy3;
            r_s2   <= n_s2;
            r_s3   <= n_s3;
            r_a_x1 <= i_item.first_x;
            r_a_y1 <= i_item.first_y;
        end
    end

    // Stage B: all six products in parallel.
    logic signed [DEN_W-1:0] r_pd_a, r_pd_b;
    logic signed [NUM_W-1:0] r_px_a, r_px_b, r_py_a, r_py_b;
    logic [COORD_BITS-1:0]   r_b_x1, r_b_y1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd_a <= DEN_W'(r_dx2) * DEN_W'(r_dy3);
            r_pd_b <= DEN_W'(r_dx3) * DEN_W'(r_dy2);
            r_px_a <= NUM_W'(r_s2) * NUM_W'(r_dy3);
            r_px_b <= NUM_W'(r_s3) * NUM_W'(r_dy2);
            r_py_a <= NUM_W'(r_dx2) * NUM_W'(r_s3);
            r_py_b <= NUM_W'(r_dx3) * NUM_W'(r_s2);
            r_b_x1 <= r_a_x1;
            r_b_y1 <= r_a_y1;
        end
    end

    // Stage C: denominator, numerators, signs and magnitudes.
    logic signed [DEN_W-1:0] w_cross, w_den;
    logic signed [NUM_W-1:0] w_num_x, w_num_y, w_abs_x, w_abs_y, w_abs_d;
    t_div_stage              n_stage, r_stage;

    always_comb begin
        w_cross = r_pd_a - r_pd_b;
        w_den   = w_cross <<< 1;
        w_num_x = r_px_a - r_px_b;
        w_num_y = r_py_a - r_py_b;
        w_abs_x = w_num_x[NUM_W-1] ? -w_num_x : w_num_x;
        w_abs_y = w_num_y[NUM_W-1] ? -w_num_y : w_num_y;
        w_abs_d = NUM_W'(w_den[DEN_W-1] ? -w_den : w_den);
        n_stage.collinear = (w_cross == '0);
        n_stage.neg_x     = w_num_x[NUM_W-1] ^ w_den[DEN_W-1];
        n_stage.neg_y     = w_num_y[NUM_W-1] ^ w_den[DEN_W-1];
        n_stage.den       = w_abs_d[DEN_MAG_W-1:0];
        n_stage.rem_x     = '0;
        n_stage.rem_y     = '0;
        n_stage.quo_x     = QUO_W'(w_abs_x[NUM_MAG_W-1:0]) << FRAC_BITS;
        n_stage.quo_y     = QUO_W'(w_abs_y[NUM_MAG_W-1:0]) << FRAC_BITS;
        n_stage.x1        = r_b_x1;
        n_stage.y1        = r_b_y1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_c_valid;
    assign o_stage = r_stage;
endmodule

/* hdl/c3p_div_cell.sv */
// Divider cell: one restoring quotient bit for both center coordinates.
module c3p_div_cell import c3p_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_div_stage i_stage,
    output logic       o_valid,
    output t_div_stage o_stage
);
    logic       r_valid;
    t_div_stage n_stage, r_stage;
    logic [DEN_MAG_W:0] w_trial_x, w_trial_y, w_den_ext;
    logic               w_qx, w_qy;

    always_comb begin
        w_den_ext = {1'b0, i_stage.den};
        w_trial_x = {i_stage.rem_x, i_stage.quo_x[QUO_W-1]};
        w_trial_y = {i_stage.rem_y, i_stage.quo_y[QUO_W-1]};
        w_qx      = (w_trial_x >= w_den_ext);
        w_qy      = (w_trial_y >= w_den_ext);
        n_stage   = i_stage;
        n_stage.rem_x = w_qx ? DEN_MAG_W'(w_trial_x - w_den_ext) : DEN_MAG_W'(w_trial_x);
        n_stage.rem_y = w_qy ? DEN_MAG_W'(w_trial_y - w_den_ext) : DEN_MAG_W'(w_trial_y);
        n_stage.quo_x = {i_stage.quo_x[QUO_W-2:0], w_qx};
        n_stage.quo_y = {i_stage.quo_y[QUO_W-2:0], w_qy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

/* hdl/c3p_mid.sv */
// Middle pipeline: signed saturation of the center, error vector and squared distance.
module c3p_mid import c3p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_div_stage  i_stage,
    output logic        o_valid,
    output t_sqrt_stage o_stage
);
    logic r_p_valid, r_q_valid, r_r_valid, r_s_valid;

    // Stage P: apply sign and clamp to the signed 32-bit range.
    logic [QEXT_W-1:0]     w_qx, w_qy;
    logic signed [31:0]    n_cx, n_cy, r_p_cx, r_p_cy;
    logic                  r_p_coll;
    logic [COORD_BITS-1:0] r_p_x1, r_p_y1;

    function automatic logic [31:0] sat_quo(input logic [QEXT_W-1:0] q, input logic neg);
        logic [31:0] v;
        if (!neg) begin
            v = (q > QEXT_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            v = (q > QEXT_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        return v;
    endfunction

    always_comb begin
        w_qx = QEXT_W'(i_stage.quo_x);
        w_qy = QEXT_W'(i_stage.quo_y);
        n_cx = $signed(sat_quo(w_qx, i_stage.neg_x));
        n_cy = $signed(sat_quo(w_qy, i_stage.neg_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_q_valid <= r_p_valid;
            r_r_valid <= r_q_valid;
            r_s_valid <= r_r_valid;
        end
    end

    // Stage Q: distance components from the fixed-point center to the first point.
    logic signed [ERR_W-1:0] w_ex, w_ey;
    logic [ERR_W-1:0]        w_ax, w_ay;
    logic [31:0]             r_q_ax, r_q_ay;
    logic                    r_q_sat, r_q_coll;
    logic signed [31:0]      r_q_cx, r_q_cy;

    always_comb begin
        w_ex = ERR_W'(r_p_cx) - $signed(ERR_W'(r_p_x1) << FRAC_BITS);
        w_ey = ERR_W'(r_p_cy) - $signed(ERR_W'(r_p_y1) << FRAC_BITS);
        w_ax = w_ex[ERR_W-1] ? ERR_W'(-w_ex) : ERR_W'(w_ex);
        w_ay = w_ey[ERR_W-1] ? ERR_W'(-w_ey) : ERR_W'(w_ey);
    end

    // Stage R: squares. Stage S: sum and overflow.
    logic [63:0]        r_r_a2, r_r_b2;
    logic               r_r_sat, r_r_coll;
    logic signed [31:0] r_r_cx, r_r_cy;
    logic [64:0]        w_sum;
    t_sqrt_stage        n_stage, r_stage;

    always_comb begin
        w_sum             = {1'b0, r_r_a2} + {1'b0, r_r_b2};
        n_stage.collinear = r_r_coll;
        n_stage.sat       = r_r_sat | w_sum[64];
        n_stage.cx        = r_r_cx;
        n_stage.cy        = r_r_cy;
        n_stage.n         = w_sum[63:0];
        n_stage.rem       = '0;
        n_stage.root      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_cx   <= n_cx;
            r_p_cy   <= n_cy;
            r_p_coll <= i_stage.collinear;
            r_p_x1   <= i_stage.x1;
            r_p_y1   <= i_stage.y1;

            r_q_ax   <= w_ax[31:0];
            r_q_ay   <= w_ay[31:0];
            r_q_sat  <= (w_ax[ERR_W-1:32] != '0) || (w_ay[ERR_W-1:32] != '0);
            r_q_coll <= r_p_coll;
            r_q_cx   <= r_p_cx;
            r_q_cy   <= r_p_cy;

            r_r_a2   <= 64'(r_q_ax) * 64'(r_q_ax);
            r_r_b2   <= 64'(r_q_ay) * 64'(r_q_ay);
            r_r_sat  <= r_q_sat;
            r_r_coll <= r_q_coll;
            r_r_cx   <= r_q_cx;
            r_r_cy   <= r_q_cy;

            r_stage  <= n_stage;
        end
    end

    assign o_valid = r_s_valid;
    assign o_stage = r_stage;
endmodule

/* hdl/c3p_sqrt_cell.sv */
// Square root cell: one root bit from the next two bits of the squared distance.
module c3p_sqrt_cell import c3p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_sqrt_stage i_stage,
    output logic        o_valid,
    output t_sqrt_stage o_stage
);
    logic                    r_valid;
    t_sqrt_stage             n_stage, r_stage;
    logic [SQRT_REM_W+1:0]   w_trial, w_sub;
    logic                    w_bit;

    always_comb begin
        w_trial = {i_stage.rem, i_stage.n[2*ROOT_W-1 -: 2]};
        w_sub   = (SQRT_REM_W+2)'({i_stage.root, 2'b01});
        w_bit   = (w_trial >= w_sub);
        n_stage = i_stage;
        n_stage.rem  = w_bit ? SQRT_REM_W'(w_trial - w_sub) : SQRT_REM_W'(w_trial);
        n_stage.root = {i_stage.root[ROOT_W-2:0], w_bit};
        n_stage.n    = {i_stage.n[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

/* hdl/circle_through_three_points.sv */
// Top level of the circle-through-three-points pipeline.

// Takes one point triple per cycle while not stalled and returns the circumcircle
// center (signed, FRAC_BITS fraction bits, saturated) and radius (unsigned,
// saturated), or the collinear flag with zero fields. The pipeline is 3 front
// stages, one divider cell per quotient bit (QUO_W = 3*COORD_BITS+2+FRAC_BITS,
// 40 at defaults), 4 middle stages, 32 square root cells and the output register.
// It advances as a whole, so it holds while a finished item waits at the output.
`include "circle_through_three_points_defines.svh"
module circle_through_three_points import c3p_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    logic        w_en;
    logic        w_div_valid  [0:QUO_W];
    t_div_stage  w_div_stage  [0:QUO_W];
    logic        w_sqrt_valid [0:ROOT_W];
    t_sqrt_stage w_sqrt_stage [0:ROOT_W];
    logic        r_out_valid;
    t_out_item   n_out, r_out;
    t_sqrt_stage w_last;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    c3p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (w_div_valid[0]),
        .o_stage (w_div_stage[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        c3p_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_valid[g]),
            .i_stage (w_div_stage[g]),
            .o_valid (w_div_valid[g+1]),
            .o_stage (w_div_stage[g+1])
        );
    end

    c3p_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid[QUO_W]),
        .i_stage (w_div_stage[QUO_W]),
        .o_valid (w_sqrt_valid[0]),
        .o_stage (w_sqrt_stage[0])
    );

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        c3p_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sqrt_valid[g]),
            .i_stage (w_sqrt_stage[g]),
            .o_valid (w_sqrt_valid[g+1]),
            .o_stage (w_sqrt_stage[g+1])
        );
    end

    assign w_last = w_sqrt_stage[ROOT_W];

    always_comb begin
        n_out.collinear = w_last.collinear;
        if (w_last.collinear) begin
            n_out.center_x   = '0;
            n_out.center_y   = '0;
            n_out.radius_out = '0;
        end else begin
            n_out.center_x   = w_last.cx;
            n_out.center_y   = w_last.cy;
            n_out.radius_out = w_last.sat ? 32'hFFFF_FFFF : w_last.root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sqrt_valid[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `C3P_ASSERT_COMB(a_collinear_zero, !(o_out_valid && o_out_item.collinear) || (o_out_item.radius_out == '0 && o_out_item.center_x == '0 && o_out_item.center_y == '0), "collinear item with nonzero fields")
    `C3P_ASSERT(a_last_held, (w_sqrt_valid[ROOT_W] && !w_en) |=> w_sqrt_valid[ROOT_W], "item lost from last root cell during stall")
    `C3P_ASSERT(a_front_held, (w_div_valid[0] && !w_en) |=> (w_div_valid[0] && $stable(w_div_stage[0])), "front item changed during stall")
endmodule

/* test/c3p_checker.sv */
// Checker for the circle-through-three-points block: predicts each result and compares it.
`timescale 1ns / 1ps
module c3p_checker import c3p_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    input  logic      i_end_check,
    output int        o_fail_count,
    output int        o_pending
);
    t_out_item circle_queue[$];
    int        mismatch_count;
    int        fail_total;
    int        leftover;

    function automatic longint fixed_div(longint num, longint den);
        longint q;
        longint r;
        longint v;
        q = num / den;
        r = num % den;
        if (q > (64'sd1 <<< 32)) q = 64'sd1 <<< 32;
        if (q < -(64'sd1 <<< 32)) q = -(64'sd1 <<< 32);
        v = q * (64'sd1 <<< FRAC_BITS) + (r * (64'sd1 <<< FRAC_BITS)) / den;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_out_item predict_circle(t_in_item p);
        t_out_item r;
        longint x1, y1, x2, y2, x3, y3, dx2, dy2, dx3, dy3, den, s1, s2, s3, cx, cy, ex, ey;
        longint unsigned ax, ay, a2, b2, rad;
        x1 = longint'(p.first_x);  y1 = longint'(p.first_y);
        x2 = longint'(p.second_x); y2 = longint'(p.second_y);
        x3 = longint'(p.third_x);  y3 = longint'(p.third_y);
        dx2 = x2 - x1; dy2 = y2 - y1; dx3 = x3 - x1; dy3 = y3 - y1;
        den = 2 * (dx2 * dy3 - dx3 * dy2);
        r = '0;
        if (den == 0) begin
            r.collinear = 1'b1;
            return r;
        end
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2 - s1;
        s3 = x3 * x3 + y3 * y3 - s1;
        cx = fixed_div(s2 * dy3 - s3 * dy2, den);
        cy = fixed_div(dx2 * s3 - dx3 * s2, den);
        ex = cx - x1 * (64'sd1 <<< FRAC_BITS);
        ey = cy - y1 * (64'sd1 <<< FRAC_BITS);
        ax = (ex < 0) ? -ex : ex;
        ay = (ey < 0) ? -ey : ey;
        if (ax >= 64'h1_0000_0000 || ay >= 64'h1_0000_0000) begin
            rad = 64'hFFFF_FFFF;
        end else begin
            a2 = ax * ax;
            b2 = ay * ay;
            if (a2 > ~64'd0 - b2) rad = 64'hFFFF_FFFF;
            else rad = int_sqrt(a2 + b2);
            if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
        end
        r.center_x = cx[31:0];
        r.center_y = cy[31:0];
        r.radius_out = rad[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            fail_total <= 0;
            o_pending <= 0;
            mismatch_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) circle_queue = {circle_queue, predict_circle(i_in_item)};
            if (i_out_valid && i_out_ready) begin
                if (circle_queue.size() == 0) begin
                    fail_total <= fail_total + 1;
                    if (mismatch_count < 10) $display("unexpected item %h", i_out_item);
                    mismatch_count++;
                end else begin
                    want = circle_queue.pop_front();
                    if (want !== i_out_item) begin
                        fail_total <= fail_total + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: cx %h/%h cy %h/%h r %h/%h col %b/%b",
                                     want.center_x, i_out_item.center_x,
                                     want.center_y, i_out_item.center_y,
                                     want.radius_out, i_out_item.radius_out,
                                     want.collinear, i_out_item.collinear);
                        mismatch_count++;
                    end
                end
            end
            o_pending <= circle_queue.size();
        end
    end

    // Leftover expectations count as failures once the top signals the end.
    initial leftover = 0;
    always @(posedge i_end_check) leftover = circle_queue.size();

    assign o_fail_count = fail_total + leftover;
endmodule

/* test/tb_circle_through_three_points.sv */
// Testbench top for the circle-through-three-points block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_circle_through_three_points import c3p_pkg::*;;
    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    logic      end_check;
    int        fail_count;
    int        pending;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      hold_off;

    circle_through_three_points dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    c3p_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .i_end_check(end_check), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return COORD_BITS'($urandom_range(0, 7));
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_triple();
        t_in_item t;
        logic [COORD_BITS-1:0] sx, sy;
        int kind;
        t.first_x = rand_coord(); t.first_y = rand_coord();
        t.second_x = rand_coord(); t.second_y = rand_coord();
        t.third_x = rand_coord(); t.third_y = rand_coord();
        kind = $urandom_range(0, 9);
        // Some triples are made collinear or nearly so, to reach saturation.
        if (kind == 0) begin
            sx = COORD_BITS'($urandom_range(0, 3)); sy = COORD_BITS'($urandom_range(0, 3));
            t.second_x = t.first_x + sx; t.second_y = t.first_y + sy;
            t.third_x = t.first_x + (sx << 1); t.third_y = t.first_y + (sy << 1);
        end else if (kind == 1) begin
            t.second_x = t.first_x + COORD_BITS'(1); t.second_y = t.first_y;
            t.third_x = t.first_x + COORD_BITS'(2);
            t.third_y = t.first_y + COORD_BITS'($urandom_range(0, 1));
        end else if (kind == 2) begin
            t.second_x = t.first_x; t.second_y = t.first_y;
        end
        return t;
    endfunction

    task automatic send_item(t_in_item t);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= t;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic send_fields(int ax, int ay, int bx, int by, int cx, int cy);
        t_in_item t;
        t.first_x  = COORD_BITS'(ax);
        t.first_y  = COORD_BITS'(ay);
        t.second_x = COORD_BITS'(bx);
        t.second_y = COORD_BITS'(by);
        t.third_x  = COORD_BITS'(cx);
        t.third_y  = COORD_BITS'(cy);
        send_item(t);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else out_ready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
    end

    // Long receiver stall while the sender keeps offering items.
    initial begin
        hold_off = 1'b0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int phase;
        in_valid = 1'b0;
        in_item = '0;
        end_check = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed triples: corners, coincident and collinear points, huge centers.
        send_fields(0, 0, 1023, 0, 0, 1023);
        send_fields(1023, 1023, 0, 1023, 1023, 0);
        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(1023, 1023, 1023, 1023, 1023, 1023);
        send_fields(0, 0, 1023, 1023, 512, 512);
        send_fields(5, 5, 5, 5, 9, 100);
        send_fields(0, 0, 1, 0, 2, 1);
        send_fields(0, 0, 1023, 1, 1022, 1);
        send_fields(0, 1023, 1, 0, 0, 0);
        send_fields(1, 0, 0, 1, 1023, 1023);
        send_fields(0, 0, 1, 0, 1023, 1);
        send_fields(1023, 0, 1022, 0, 0, 1);
        send_fields(100, 200, 300, 400, 500, 100);
        send_fields(682, 341, 341, 682, 1023, 1023);
        send_fields(0, 0, 2, 0, 0, 2);
        send_fields(0, 0, 1, 1, 2, 0);
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 9 : 0;
            for (int k = 0; k < 180; k++) send_item(random_triple());
        end
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        end_check <= 1'b1;
        @(posedge i_clk);
        @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/c3p_pkg.sv
hdl/c3p_front.sv
hdl/c3p_div_cell.sv
hdl/c3p_mid.sv
hdl/c3p_sqrt_cell.sv
hdl/circle_through_three_points.sv
test/c3p_checker.sv
test/tb_circle_through_three_points.sv
